// ===== sv/rrts_pkg.sv =====
// ----------------------------------------------------------------------------
// rrts_pkg
// Types and fixed field widths shared by the round-robin tick scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package rrts_pkg;

  localparam int unsigned ARR_W  = 16;  // arrival tick field
  localparam int unsigned NEED_W = 16;  // needed ticks field, also run counter
  localparam int unsigned PID_W  = 4;   // reported process id
  localparam int unsigned TICK_W = 16;  // reported clock value

  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_ADDED = 2'd0,
    ST_FULL  = 2'd1,
    ST_IDLE  = 2'd2,
    ST_RAN   = 2'd3
  } status_t;

endpackage

`default_nettype wire

// ===== sv/round_robin_tick_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// round_robin_tick_scheduler_unit
// Round-robin time-slice scheduler with an add-ordered pending list.
// Add beat: the result is registered in S_EMIT and the next beat is taken
//   once the unit is back in S_IDLE.
// Tick beat: S_SCAN over the P pending entries, then S_RUN0, S_RUN1, S_RUN2
//   and S_EMIT; an idle tick goes from S_RUN0 to S_EMIT. The scan walks the
//   pending list through the pending and arrival RAM read ports, one entry a cycle.
// Reset (sync, active high) empties both queues, sets the clock to 1 and
//   the id counter to 0; RAM contents are left as they are.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_tick_scheduler_unit #(
  parameter int unsigned MAX_PROCS = 16,
  parameter int unsigned TIME_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // item channel
  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire logic                          kind,
  input  wire logic [rrts_pkg::ARR_W-1:0]    arrive_tick,
  input  wire logic [rrts_pkg::NEED_W-1:0]   need_ticks,
  // result channel
  output logic                               res_valid,
  input  wire logic                          res_stall,
  output rrts_pkg::status_t                  status,
  output logic      [rrts_pkg::PID_W-1:0]    proc_id,
  output logic                               finished,
  output logic      [rrts_pkg::TICK_W-1:0]   tick_now
);

  import rrts_pkg::*;

  localparam int unsigned ID_W  = $clog2(MAX_PROCS);
  localparam int unsigned CNT_W = $clog2(MAX_PROCS + 1);
  localparam int unsigned CMP_W = (TIME_BITS > ARR_W) ? TIME_BITS : ARR_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RUN0,
    S_RUN1,
    S_RUN2,
    S_EMIT
  } state_t;

  state_t               state;

  logic [ID_W-1:0]      rdy_head, rdy_tail;
  logic [CNT_W-1:0]     rdy_count;
  logic [ID_W-1:0]      pend_head, pend_tail, rd_ptr;
  logic [CNT_W-1:0]     pend_count;
  logic [CNT_W-1:0]     next_id;
  logic [TIME_BITS-1:0] now;

  // scan pipeline
  logic [CNT_W-1:0]     scan_total, iss_cnt, kept;
  logic                 v1, v2;
  logic [ID_W-1:0]      id2;
  logic [ID_W-1:0]      run_id;

  // pending result
  status_t              r_status;
  logic [PID_W-1:0]     r_pid;
  logic                 r_fin;
  logic [TICK_W-1:0]    r_tick;

  // RAM ports
  logic                 rdy_we, pend_we, arr_we, run_we;
  logic [ID_W-1:0]      rdy_wdata, pend_wdata, run_waddr, new_id;
  logic [ID_W-1:0]      rdy_rdata, pend_rdata;
  logic [ARR_W-1:0]     arr_rdata;
  logic [NEED_W-1:0]    need_rdata, run_rdata, run_wdata, run_new;

  logic                 table_full, add_go, tick_go, admit, fin_c, issue;
  logic [TIME_BITS-1:0] now_adv;

  function automatic logic [ID_W-1:0] ptr_inc(input logic [ID_W-1:0] p);
    return (p == ID_W'(MAX_PROCS - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    item_stall = (state != S_IDLE);
    table_full = (next_id == CNT_W'(MAX_PROCS));
    new_id     = next_id[ID_W-1:0];
    add_go     = (state == S_IDLE) && item_valid && (kind == KIND_ADD) && !table_full;
    tick_go    = (state == S_IDLE) && item_valid && (kind == KIND_TICK);
    issue      = (iss_cnt != scan_total);
    admit      = (CMP_W'(arr_rdata) <= CMP_W'(now));
    run_new    = (run_rdata == '1) ? run_rdata : run_rdata + 1'b1;
    fin_c      = (run_new >= need_rdata);
    now_adv    = (now == '1) ? now : now + 1'b1;

    // all ready-queue writes land at the tail
    rdy_we     = (add_go && (arrive_tick == '0)) ||
                 ((state == S_SCAN) && v2 && admit) ||
                 ((state == S_RUN2) && !fin_c);
    rdy_wdata  = add_go ? new_id : ((state == S_SCAN) ? id2 : run_id);

    pend_we    = (add_go && (arrive_tick != '0)) ||
                 ((state == S_SCAN) && v2 && !admit);
    pend_wdata = add_go ? new_id : id2;

    arr_we     = add_go;
    run_we     = add_go || (state == S_RUN2);
    run_waddr  = add_go ? new_id : run_id;
    run_wdata  = add_go ? '0 : run_new;
  end

  rrts_ram #(.WIDTH(ID_W), .DEPTH(MAX_PROCS)) u_ready_q (
    .clk(clk), .we(rdy_we), .waddr(rdy_tail), .wdata(rdy_wdata),
    .raddr(rdy_head), .rdata(rdy_rdata)
  );

  rrts_ram #(.WIDTH(ID_W), .DEPTH(MAX_PROCS)) u_pend_list (
    .clk(clk), .we(pend_we), .waddr(pend_tail), .wdata(pend_wdata),
    .raddr(rd_ptr), .rdata(pend_rdata)
  );

  rrts_ram #(.WIDTH(ARR_W), .DEPTH(MAX_PROCS)) u_arrival (
    .clk(clk), .we(arr_we), .waddr(new_id), .wdata(arrive_tick),
    .raddr(pend_rdata), .rdata(arr_rdata)
  );

  rrts_ram #(.WIDTH(NEED_W), .DEPTH(MAX_PROCS)) u_need (
    .clk(clk), .we(arr_we), .waddr(new_id), .wdata(need_ticks),
    .raddr(rdy_rdata), .rdata(need_rdata)
  );

  rrts_ram #(.WIDTH(NEED_W), .DEPTH(MAX_PROCS)) u_run (
    .clk(clk), .we(run_we), .waddr(run_waddr), .wdata(run_wdata),
    .raddr(rdy_rdata), .rdata(run_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rdy_head   <= '0;
      rdy_tail   <= '0;
      rdy_count  <= '0;
      pend_head  <= '0;
      pend_tail  <= '0;
      pend_count <= '0;
      rd_ptr     <= '0;
      next_id    <= '0;
      now        <= TIME_BITS'(1);
      v1         <= 1'b0;
      v2         <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (res_valid && !res_stall && (state != S_EMIT)) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          r_tick <= TICK_W'(now);
          if (item_valid && (kind == KIND_ADD)) begin
            r_fin <= 1'b0;
            if (table_full) begin
              r_status <= ST_FULL;
              r_pid    <= '0;
            end else begin
              r_status <= ST_ADDED;
              r_pid    <= PID_W'(new_id);
              next_id  <= next_id + 1'b1;
              if (arrive_tick == '0) begin
                rdy_tail  <= ptr_inc(rdy_tail);
                rdy_count <= rdy_count + 1'b1;
              end else begin
                pend_tail  <= ptr_inc(pend_tail);
                pend_count <= pend_count + 1'b1;
              end
            end
            state <= S_EMIT;
          end else if (tick_go) begin
            rd_ptr     <= pend_head;
            scan_total <= pend_count;
            iss_cnt    <= '0;
            kept       <= '0;
            v1         <= 1'b0;
            v2         <= 1'b0;
            state      <= S_SCAN;
          end
        end

        S_SCAN: begin
          // issue pending read, then arrival read, then route the id
          if (issue) begin
            rd_ptr  <= ptr_inc(rd_ptr);
            iss_cnt <= iss_cnt + 1'b1;
          end
          v1  <= issue;
          v2  <= v1;
          id2 <= pend_rdata;
          if (v2) begin
            if (admit) begin
              rdy_tail  <= ptr_inc(rdy_tail);
              rdy_count <= rdy_count + 1'b1;
            end else begin
              pend_tail <= ptr_inc(pend_tail);
              kept      <= kept + 1'b1;
            end
          end
          if (!issue && !v1 && !v2) begin
            pend_head  <= rd_ptr;
            pend_count <= kept;
            state      <= S_RUN0;
          end
        end

        S_RUN0: begin
          if (rdy_count == '0) begin
            r_status <= ST_IDLE;
            r_pid    <= '0;
            r_fin    <= 1'b0;
            now      <= now_adv;
            state    <= S_EMIT;
          end else begin
            state <= S_RUN1;
          end
        end

        S_RUN1: begin
          run_id <= rdy_rdata;
          state  <= S_RUN2;
        end

        S_RUN2: begin
          // pop the head; requeue at the tail unless done
          rdy_head <= ptr_inc(rdy_head);
          if (fin_c) begin
            rdy_count <= rdy_count - 1'b1;
          end else begin
            rdy_tail <= ptr_inc(rdy_tail);
          end
          r_status <= ST_RAN;
          r_pid    <= PID_W'(run_id);
          r_fin    <= fin_c;
          now      <= now_adv;
          state    <= S_EMIT;
        end

        S_EMIT: begin
          if (!res_valid || !res_stall) begin
            res_valid <= 1'b1;
            status    <= r_status;
            proc_id   <= r_pid;
            finished  <= r_fin;
            tick_now  <= r_tick;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_rdy_bound: assert property (@(posedge clk) disable iff (rst)
    rdy_count <= CNT_W'(MAX_PROCS))
    else $error("ready queue count exceeds table size");

  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ({1'b0, rdy_count} + {1'b0, pend_count} <= {1'b0, next_id}))
    else $error("queued processes exceed added processes");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> (state != S_IDLE))
    else $error("accepted beat did not start work");

  a_run_to_emit: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN2) |=> (state == S_EMIT))
    else $error("run step did not hand off a result");

  a_clock_nonzero: assert property (@(posedge clk) disable iff (rst)
    now != '0)
    else $error("scheduler clock reached zero");
`endif

endmodule

`default_nettype wire

// ===== sv/rrts_ram.sv =====
// ----------------------------------------------------------------------------
// rrts_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
